// ===== rtl/floppy_disk_controller_assert.svh =====
// Assertion macros for the controller RTL, used by fdc_back.
`ifndef FLOPPY_DISK_CONTROLLER_ASSERT_SVH
`define FLOPPY_DISK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FDC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdc assertion failed");

// Next-cycle implication, checked outside reset.
`define FDC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdc assertion failed");

`endif

// ===== rtl/fdc_pkg.sv =====
// Types, constants and codes shared by the floppy disk controller modules.
package fdc_pkg;

    localparam int IMAGE_AW     = 19;          // byte address bits inside one image
    localparam int SECT_AW      = 9;           // byte address bits inside one sector
    localparam int SECT_IDX_W   = IMAGE_AW - SECT_AW;
    localparam int DISK_AW      = IMAGE_AW + 1; // two drives
    localparam int CNT_W        = SECT_AW + 1;
    localparam logic [CNT_W-1:0] SECTOR_BYTES = CNT_W'(512);
    localparam logic [CNT_W-1:0] ID_BYTES     = CNT_W'(6);
    localparam logic [7:0] TRACK_LAST   = 8'd39;
    localparam logic [7:0] SECT_PER_TRK = 8'd10;
    localparam logic [7:0] SIZE_CODE    = 8'd2;

    // Status bits
    localparam logic [7:0] ST_BUSY      = 8'h01;
    localparam logic [7:0] ST_DRQ       = 8'h02;
    localparam logic [7:0] ST_INDEX     = 8'h02;
    localparam logic [7:0] ST_TRACK0    = 8'h04;
    localparam logic [7:0] ST_NOT_READY = 8'h80;

    // Item modes
    localparam logic [2:0] MODE_BUS_RD  = 3'd0;
    localparam logic [2:0] MODE_BUS_WR  = 3'd1;
    localparam logic [2:0] MODE_PORT    = 3'd2;
    localparam logic [2:0] MODE_TICK    = 3'd3;
    localparam logic [2:0] MODE_LOAD    = 3'd4;
    localparam logic [2:0] MODE_CLR     = 3'd5;

    // Register selects
    localparam logic [1:0] REG_STATUS   = 2'd0;
    localparam logic [1:0] REG_TRACK    = 2'd1;
    localparam logic [1:0] REG_SECTOR   = 2'd2;
    localparam logic [1:0] REG_DATA     = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FIRST_SIDES  = 1'b0;
    localparam logic CFG_SECOND_SIDES = 1'b1;

    // Command opcode nibbles
    localparam logic [3:0] OP_RESTORE  = 4'h0;
    localparam logic [3:0] OP_STEP_A   = 4'h2;
    localparam logic [3:0] OP_STEP_B   = 4'h3;
    localparam logic [3:0] OP_IN_A     = 4'h4;
    localparam logic [3:0] OP_IN_B     = 4'h5;
    localparam logic [3:0] OP_OUT_A    = 4'h6;
    localparam logic [3:0] OP_OUT_B    = 4'h7;
    localparam logic [3:0] OP_READ_A   = 4'h8;
    localparam logic [3:0] OP_READ_B   = 4'h9;
    localparam logic [3:0] OP_WRITE_A  = 4'hA;
    localparam logic [3:0] OP_WRITE_B  = 4'hB;
    localparam logic [3:0] OP_READ_ID  = 4'hC;

    typedef struct packed {
        logic [2:0]          mode;
        logic [1:0]          reg_sel;
        logic [7:0]          wdata;
        logic                load_drive;
        logic [IMAGE_AW-1:0] load_addr;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       interrupt_request;
    } out_item_t;

    typedef struct packed {
        logic [1:0] first_sides;
        logic [1:0] second_sides;
    } sides_cfg_t;

    // Item class decided by the front end
    typedef enum logic [3:0] {
        CL_NOP, CL_RD_STATUS, CL_RD_TRACK, CL_RD_SECTOR, CL_RD_DATA,
        CL_WR_CMD, CL_WR_TRACK, CL_WR_SECTOR, CL_WR_DATA,
        CL_PORT, CL_TICK, CL_LOAD, CL_CLR
    } cls_t;

    typedef struct packed {
        cls_t     cls;
        in_item_t item;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_beat_t;

endpackage

// ===== rtl/fdc_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
module fdc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fdc_pkg::in_item_t item,
    input  logic              pop,
    input  logic              done,
    output fdc_pkg::q_beat_t  qout
);

    fdc_pkg::q_entry_t q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pending_reg, pending_next;
    logic       accept;
    fdc_pkg::cls_t cls;

    assign busy   = pending_reg;
    assign accept = start & ~pending_reg;

    // Classify the incoming beat
    always_comb
    begin
        cls = fdc_pkg::CL_NOP;
        case (item.mode)
            fdc_pkg::MODE_BUS_RD:
            begin
                case (item.reg_sel)
                    fdc_pkg::REG_STATUS: cls = fdc_pkg::CL_RD_STATUS;
                    fdc_pkg::REG_TRACK:  cls = fdc_pkg::CL_RD_TRACK;
                    fdc_pkg::REG_SECTOR: cls = fdc_pkg::CL_RD_SECTOR;
                    default:             cls = fdc_pkg::CL_RD_DATA;
                endcase
            end
            fdc_pkg::MODE_BUS_WR:
            begin
                case (item.reg_sel)
                    fdc_pkg::REG_STATUS: cls = fdc_pkg::CL_WR_CMD;
                    fdc_pkg::REG_TRACK:  cls = fdc_pkg::CL_WR_TRACK;
                    fdc_pkg::REG_SECTOR: cls = fdc_pkg::CL_WR_SECTOR;
                    default:             cls = fdc_pkg::CL_WR_DATA;
                endcase
            end
            fdc_pkg::MODE_PORT: cls = fdc_pkg::CL_PORT;
            fdc_pkg::MODE_TICK: cls = fdc_pkg::CL_TICK;
            fdc_pkg::MODE_LOAD: cls = fdc_pkg::CL_LOAD;
            fdc_pkg::MODE_CLR:  cls = fdc_pkg::CL_CLR;
            default:            cls = fdc_pkg::CL_NOP;
        endcase
    end

    // Queue pointers and in-flight flag
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        if (accept)
        begin
            wr_ptr_next  = ~wr_ptr_reg;
            pending_next = 1'b1;
        end
        if (done)
        begin
            pending_next = 1'b0;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        count_next = count_reg + 2'(accept) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            pending_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= '{cls: cls, item: item};
        end
    end

    assign qout.valid = (count_reg != 2'd0);
    assign qout.entry = q_mem[rd_ptr_reg];

endmodule

// ===== rtl/fdc_back.sv =====
// Back end: register file, command sequencer, sector buffer and disk store.
module fdc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdc_pkg::q_beat_t     qin,
    output logic                 pop,
    input  fdc_pkg::sides_cfg_t  sides,
    output logic                 done,
    output fdc_pkg::out_item_t   result
);

    `include "floppy_disk_controller_assert.svh"

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_RDWAIT  = 6'b000100,
        S_COPYIN  = 6'b001000,
        S_COPYOUT = 6'b010000,
        S_IDWR    = 6'b100000
    } state_t;

    localparam int CW = fdc_pkg::CNT_W;
    localparam int SW = fdc_pkg::SECT_AW;
    localparam int BW = fdc_pkg::SECT_IDX_W + 1;

    // Memories
    logic [7:0] disk_mem [2**fdc_pkg::DISK_AW];
    logic [7:0] buf_mem  [2**SW];
    logic [7:0] disk_q, buf_q;
    logic                       disk_we, buf_we;
    logic [fdc_pkg::DISK_AW-1:0] disk_waddr, disk_raddr;
    logic [7:0]                 disk_wdata, buf_wdata;
    logic [SW-1:0]              buf_waddr, buf_raddr;

    // Registers
    state_t     state_reg, state_next;
    fdc_pkg::q_entry_t cur_reg, cur_next;
    logic [7:0] track_reg, track_next;
    logic [7:0] sector_reg, sector_next;
    logic       side_reg, side_next;
    logic       drive_reg, drive_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] status_reg, status_next;
    logic       drq_reg, drq_next;
    logic       busyf_reg, busyf_next;
    logic       irq_reg, irq_next;
    logic       wrf_reg, wrf_next;
    logic       type1_reg, type1_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] len_reg, len_next;
    logic [5:0] phase_reg, phase_next;
    logic [CW-1:0] cp_reg, cp_next;
    logic [BW-1:0] base_reg, base_next;
    logic [7:0] shadow_reg, shadow_next;
    fdc_pkg::out_item_t res_reg, res_next;
    logic       resv_reg, resv_next;

    // Derived values
    logic [1:0] raw_sides, cur_sides;
    logic [5:0] trk_c;
    logic [7:0] phys_a;
    logic [3:0] phys;
    logic [6:0] row;
    logic [fdc_pkg::SECT_IDX_W-1:0] sec_idx;
    logic       off_ok;
    logic [7:0] id_val, id_byte;
    logic [6:0] phase_inc;
    logic [3:0] op;
    logic [CW-1:0] idx_inc;

    // Drive geometry and sector offset
    always_comb
    begin
        raw_sides = drive_reg ? sides.second_sides : sides.first_sides;
        cur_sides = (raw_sides == 2'd3) ? 2'd2 : raw_sides;
        trk_c     = (track_reg > fdc_pkg::TRACK_LAST) ? fdc_pkg::TRACK_LAST[5:0]
                                                       : track_reg[5:0];
        phys_a    = sector_reg;
        if (cur_sides > 2'd1 && phys_a >= fdc_pkg::SECT_PER_TRK)
        begin
            phys_a = phys_a - fdc_pkg::SECT_PER_TRK;
        end
        phys      = (phys_a >= fdc_pkg::SECT_PER_TRK) ? 4'(fdc_pkg::SECT_PER_TRK - 8'd1)
                                                      : phys_a[3:0];
        row       = (cur_sides == 2'd2) ? ({trk_c, 1'b0} + 7'(side_reg)) : {1'b0, trk_c};
        sec_idx   = {row, 3'b000} + {2'b00, row, 1'b0} + 10'(phys);
        off_ok    = (cur_sides != 2'd0) && (!side_reg || cur_sides == 2'd2);
        id_val    = sector_reg;
        if (cur_sides > 2'd1 && side_reg && sector_reg < fdc_pkg::SECT_PER_TRK)
        begin
            id_val = sector_reg + fdc_pkg::SECT_PER_TRK;
        end
        case (cp_reg[2:0])
            3'd0:    id_byte = track_reg;
            3'd1:    id_byte = {7'd0, side_reg};
            3'd2:    id_byte = id_val;
            3'd3:    id_byte = fdc_pkg::SIZE_CODE;
            default: id_byte = 8'd0;
        endcase
        phase_inc = 7'(phase_reg) + 7'd1;
        op        = cur_reg.item.wdata[7:4];
        idx_inc   = idx_reg + CW'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        track_next  = track_reg;
        sector_next = sector_reg;
        side_next   = side_reg;
        drive_next  = drive_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        drq_next    = drq_reg;
        busyf_next  = busyf_reg;
        irq_next    = irq_reg;
        wrf_next    = wrf_reg;
        type1_next  = type1_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        phase_next  = phase_reg;
        cp_next     = cp_reg;
        base_next   = base_reg;
        shadow_next = shadow_reg;
        res_next    = res_reg;
        resv_next   = 1'b0;
        pop         = 1'b0;
        disk_we     = 1'b0;
        disk_waddr  = {cur_reg.item.load_drive, cur_reg.item.load_addr};
        disk_wdata  = cur_reg.item.wdata;
        disk_raddr  = {base_reg, cp_reg[SW-1:0]};
        buf_we      = 1'b0;
        buf_waddr   = idx_reg[SW-1:0];
        buf_wdata   = cur_reg.item.wdata;
        buf_raddr   = idx_reg[SW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (qin.valid)
                begin
                    pop        = 1'b1;
                    cur_next   = qin.entry;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next.read_data = 8'd0;
                state_next = S_IDLE;
                resv_next  = 1'b1;
                case (cur_reg.cls)
                    fdc_pkg::CL_TICK: phase_next = phase_inc[5:0];
                    fdc_pkg::CL_CLR:  irq_next = 1'b0;
                    fdc_pkg::CL_LOAD: disk_we = 1'b1;
                    fdc_pkg::CL_PORT:
                    begin
                        if (cur_reg.item.wdata[1:0] == 2'd2)
                        begin
                            drive_next = 1'b0;
                        end
                        else if (cur_reg.item.wdata[1:0] == 2'd1)
                        begin
                            drive_next = 1'b1;
                        end
                        side_next = ~cur_reg.item.wdata[2];
                    end
                    fdc_pkg::CL_RD_TRACK:  res_next.read_data = track_reg;
                    fdc_pkg::CL_RD_SECTOR: res_next.read_data = sector_reg;
                    fdc_pkg::CL_WR_TRACK:  track_next = cur_reg.item.wdata;
                    fdc_pkg::CL_WR_SECTOR: sector_next = cur_reg.item.wdata;
                    fdc_pkg::CL_RD_STATUS:
                    begin
                        res_next.read_data = status_reg
                                           | (busyf_reg ? fdc_pkg::ST_BUSY : 8'd0)
                                           | (drq_reg ? fdc_pkg::ST_DRQ : 8'd0);
                        if (!busyf_reg)
                        begin
                            if (cur_sides == 2'd0)
                            begin
                                res_next.read_data = res_next.read_data
                                                   | fdc_pkg::ST_NOT_READY;
                            end
                            if (type1_reg)
                            begin
                                phase_next = phase_inc[5:0];
                                if (phase_inc[5])
                                begin
                                    res_next.read_data = res_next.read_data
                                                       | fdc_pkg::ST_INDEX;
                                end
                                if (track_reg == 8'd0)
                                begin
                                    res_next.read_data = res_next.read_data
                                                       | fdc_pkg::ST_TRACK0;
                                end
                            end
                        end
                    end
                    fdc_pkg::CL_RD_DATA:
                    begin
                        if (drq_reg && !wrf_reg && idx_reg < len_reg)
                        begin
                            resv_next  = 1'b0;
                            state_next = S_RDWAIT;
                        end
                    end
                    fdc_pkg::CL_WR_DATA:
                    begin
                        if (wrf_reg && drq_reg && idx_reg < len_reg)
                        begin
                            buf_we   = 1'b1;
                            idx_next = idx_inc;
                            if (idx_inc >= len_reg)
                            begin
                                if (off_ok)
                                begin
                                    base_next  = {drive_reg, sec_idx};
                                    cp_next    = '0;
                                    resv_next  = 1'b0;
                                    state_next = S_COPYOUT;
                                end
                                else
                                begin
                                    // sector no longer reachable: end without storing
                                    drq_next    = 1'b0;
                                    busyf_next  = 1'b0;
                                    type1_next  = 1'b0;
                                    status_next = (cur_sides == 2'd0) ? fdc_pkg::ST_NOT_READY
                                                                      : 8'd0;
                                    irq_next    = 1'b1;
                                end
                            end
                            else
                            begin
                                irq_next    = 1'b1;
                                status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                            end
                        end
                    end
                    fdc_pkg::CL_WR_CMD:
                    begin
                        cmd_next    = cur_reg.item.wdata;
                        drq_next    = 1'b0;
                        busyf_next  = 1'b1;
                        status_next = fdc_pkg::ST_BUSY;
                        case (op)
                            fdc_pkg::OP_READ_A, fdc_pkg::OP_READ_B,
                            fdc_pkg::OP_WRITE_A, fdc_pkg::OP_WRITE_B:
                            begin
                                type1_next = 1'b0;
                                if (!off_ok)
                                begin
                                    busyf_next  = 1'b0;
                                    status_next = fdc_pkg::ST_NOT_READY;
                                    irq_next    = 1'b1;
                                end
                                else if (op == fdc_pkg::OP_WRITE_A
                                         || op == fdc_pkg::OP_WRITE_B)
                                begin
                                    idx_next    = '0;
                                    len_next    = fdc_pkg::SECTOR_BYTES;
                                    wrf_next    = 1'b1;
                                    drq_next    = 1'b1;
                                    status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                                    irq_next    = 1'b1;
                                end
                                else
                                begin
                                    base_next  = {drive_reg, sec_idx};
                                    cp_next    = '0;
                                    resv_next  = 1'b0;
                                    state_next = S_COPYIN;
                                end
                            end
                            fdc_pkg::OP_READ_ID:
                            begin
                                type1_next  = 1'b0;
                                shadow_next = track_reg;
                                cp_next     = '0;
                                resv_next   = 1'b0;
                                state_next  = S_IDWR;
                            end
                            default:
                            begin
                                // Type I: stepping then immediate finish
                                if (op == fdc_pkg::OP_RESTORE)
                                begin
                                    track_next = 8'd0;
                                end
                                else if (op == fdc_pkg::OP_STEP_A || op == fdc_pkg::OP_STEP_B)
                                begin
                                    if (cur_reg.item.wdata[2])
                                    begin
                                        if (track_reg > 8'd0) track_next = track_reg - 8'd1;
                                    end
                                    else if (track_reg < fdc_pkg::TRACK_LAST)
                                    begin
                                        track_next = track_reg + 8'd1;
                                    end
                                end
                                else if (op == fdc_pkg::OP_IN_A || op == fdc_pkg::OP_IN_B)
                                begin
                                    if (track_reg < fdc_pkg::TRACK_LAST)
                                        track_next = track_reg + 8'd1;
                                end
                                else if (op == fdc_pkg::OP_OUT_A || op == fdc_pkg::OP_OUT_B)
                                begin
                                    if (track_reg > 8'd0) track_next = track_reg - 8'd1;
                                end
                                busyf_next  = 1'b0;
                                type1_next  = 1'b1;
                                status_next = ((track_next == 8'd0) ? fdc_pkg::ST_TRACK0 : 8'd0)
                                            | ((cur_sides == 2'd0) ? fdc_pkg::ST_NOT_READY
                                                                   : 8'd0);
                                irq_next    = 1'b1;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end

            S_RDWAIT:
            begin
                res_next.read_data = buf_q;
                idx_next   = idx_inc;
                if (idx_inc >= len_reg)
                begin
                    drq_next    = 1'b0;
                    busyf_next  = 1'b0;
                    type1_next  = 1'b0;
                    status_next = (cur_sides == 2'd0) ? fdc_pkg::ST_NOT_READY : 8'd0;
                    if (cmd_reg[7:4] == fdc_pkg::OP_READ_ID)
                    begin
                        sector_next = shadow_reg;
                    end
                end
                else
                begin
                    status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                end
                irq_next   = 1'b1;
                resv_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_COPYIN:
            begin
                // disk read at cp, buffer write at cp - 1 from the registered disk data
                buf_waddr = SW'(cp_reg - CW'(1));
                buf_wdata = disk_q;
                buf_we    = (cp_reg != '0);
                cp_next   = cp_reg + CW'(1);
                if (cp_reg == fdc_pkg::SECTOR_BYTES)
                begin
                    idx_next    = '0;
                    len_next    = fdc_pkg::SECTOR_BYTES;
                    wrf_next    = 1'b0;
                    busyf_next  = 1'b1;
                    drq_next    = 1'b1;
                    status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                    irq_next    = 1'b1;
                    resv_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_COPYOUT:
            begin
                // buffer read at cp, disk write at cp - 1 from the registered buffer data
                buf_raddr  = cp_reg[SW-1:0];
                disk_waddr = {base_reg, SW'(cp_reg - CW'(1))};
                disk_wdata = buf_q;
                disk_we    = (cp_reg != '0);
                cp_next    = cp_reg + CW'(1);
                if (cp_reg == fdc_pkg::SECTOR_BYTES)
                begin
                    drq_next    = 1'b0;
                    busyf_next  = 1'b0;
                    type1_next  = 1'b0;
                    status_next = (cur_sides == 2'd0) ? fdc_pkg::ST_NOT_READY : 8'd0;
                    irq_next    = 1'b1;
                    resv_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_IDWR:
            begin
                buf_we    = 1'b1;
                buf_waddr = cp_reg[SW-1:0];
                buf_wdata = id_byte;
                cp_next   = cp_reg + CW'(1);
                if (cp_reg == fdc_pkg::ID_BYTES - CW'(1))
                begin
                    idx_next    = '0;
                    len_next    = fdc_pkg::ID_BYTES;
                    wrf_next    = 1'b0;
                    busyf_next  = 1'b1;
                    drq_next    = 1'b1;
                    status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                    irq_next    = 1'b1;
                    resv_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
        res_next.interrupt_request = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cur_reg    <= '0;
            track_reg  <= 8'd0;
            sector_reg <= 8'd0;
            side_reg   <= 1'b0;
            drive_reg  <= 1'b0;
            cmd_reg    <= 8'd0;
            status_reg <= 8'd0;
            drq_reg    <= 1'b0;
            busyf_reg  <= 1'b0;
            irq_reg    <= 1'b0;
            wrf_reg    <= 1'b0;
            type1_reg  <= 1'b1;
            idx_reg    <= '0;
            len_reg    <= fdc_pkg::SECTOR_BYTES;
            phase_reg  <= 6'd0;
            cp_reg     <= '0;
            base_reg   <= '0;
            shadow_reg <= 8'd0;
            res_reg    <= '0;
            resv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            track_reg  <= track_next;
            sector_reg <= sector_next;
            side_reg   <= side_next;
            drive_reg  <= drive_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            drq_reg    <= drq_next;
            busyf_reg  <= busyf_next;
            irq_reg    <= irq_next;
            wrf_reg    <= wrf_next;
            type1_reg  <= type1_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            phase_reg  <= phase_next;
            cp_reg     <= cp_next;
            base_reg   <= base_next;
            shadow_reg <= shadow_next;
            res_reg    <= res_next;
            resv_reg   <= resv_next;
        end
    end

    // Disk store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (disk_we)
        begin
            disk_mem[disk_waddr] <= disk_wdata;
        end
        disk_q <= disk_mem[disk_raddr];
    end

    // Sector buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_q <= buf_mem[buf_raddr];
    end

    assign done   = resv_reg;
    assign result = res_reg;

    `FDC_ASSERT_IMP(a_drq_needs_busy, drq_reg, busyf_reg)
    `FDC_ASSERT_IMP(a_index_in_range, 1'b1, idx_reg <= len_reg)
    `FDC_ASSERT_NXT(a_single_strobe, resv_reg, !resv_reg)
    `FDC_ASSERT_IMP(a_copy_count, state_reg == S_COPYIN || state_reg == S_COPYOUT,
                    cp_reg <= fdc_pkg::SECTOR_BYTES)

endmodule

// ===== rtl/floppy_disk_controller.sv =====
// Top level of the two-drive floppy disk controller.
//
// Command channel: drive item and raise start; the item is taken at a clock
// edge with start high and busy low. busy then stays high until the result.
// Each item gives one result beat: done is high for one cycle with result
// (read_data, interrupt_request); the receiver cannot stall it.
// Ordinary items pass the queue, execute and result register stages before
// done; a new item is not taken until busy drops after that result.
// A data read adds one sector buffer read. Read sector and the last data
// byte of write sector make the back end walk all 512 bytes between disk
// store and sector buffer, one a cycle.
// Read address writes its six ID bytes into the sector buffer.
// Configuration: cfg_valid/cfg_ready with cfg_index selecting drive 0 or 1
// sides; cfg_ready is always high. Write only while busy is low.
// Reset clears registers and flags; disk images and the sector buffer hold
// nothing defined until loaded, and no clearing pass is run.
module floppy_disk_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fdc_pkg::in_item_t  item,
    output logic               done,
    output fdc_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data
);

    fdc_pkg::sides_cfg_t sides_reg, sides_next;
    fdc_pkg::q_beat_t    qbeat;
    logic                pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_comb
    begin
        sides_next = sides_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                fdc_pkg::CFG_FIRST_SIDES:  sides_next.first_sides  = cfg_data;
                fdc_pkg::CFG_SECOND_SIDES: sides_next.second_sides = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sides_reg <= '0;
        end
        else
        begin
            sides_reg <= sides_next;
        end
    end

    fdc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .pop   (pop),
        .done  (done),
        .qout  (qbeat)
    );

    fdc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qin    (qbeat),
        .pop    (pop),
        .sides  (sides_reg),
        .done   (done),
        .result (result)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the floppy disk controller: directed and random bus traffic.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned IMG_BYTES   = 524288;
    localparam int unsigned SECT_BYTES  = 512;
    localparam int unsigned TRK_COUNT   = 40;
    localparam int unsigned SECT_COUNT  = 10;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [7:0] CMD_FORCE    = 8'hD0;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    fdc_pkg::in_item_t  item;
    logic               done;
    fdc_pkg::out_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [1:0]         cfg_data;

    floppy_disk_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Controller shadow state
    logic [1:0]  sides_a, sides_b;
    logic [7:0]  trk, sec, cmd, stat;
    logic        side, drv;
    logic        drq, bsy, irq, wr_xfer, type1;
    int unsigned xfer_pos, xfer_len;
    logic [5:0]  phase;
    logic [7:0]  sbuf [SECT_BYTES];
    logic [7:0]  disk [int unsigned];

    fdc_pkg::in_item_t  pending_items [$];
    fdc_pkg::out_item_t expected_results [$];
    int          errors;
    bit          quiet;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int unsigned active_sides();
        logic [1:0] s;
        s = drv ? sides_b : sides_a;
        return (s > 2) ? 2 : s;
    endfunction

    // Disk offset of the addressed sector, 0 if not reachable
    function automatic bit locate_sector(output int unsigned off);
        int unsigned s, ph, tk, o;
        s   = active_sides();
        ph  = sec;
        tk  = trk;
        off = 0;
        if (s == 0 || side >= s)
            return 0;
        if (s > 1 && ph >= SECT_COUNT)
            ph -= SECT_COUNT;
        if (ph >= SECT_COUNT)
            ph = SECT_COUNT - 1;
        if (tk >= TRK_COUNT)
            tk = TRK_COUNT - 1;
        o = ((tk * s + side) * SECT_COUNT + ph) * SECT_BYTES;
        if (o + SECT_BYTES > s * TRK_COUNT * SECT_COUNT * SECT_BYTES || o + SECT_BYTES > IMG_BYTES)
            return 0;
        off = o + drv * IMG_BYTES;
        return 1;
    endfunction

    function automatic bit sector_loaded(int unsigned off);
        for (int i = 0; i < SECT_BYTES; i++)
            if (!disk.exists(off + i))
                return 0;
        return 1;
    endfunction

    function automatic void finish_seek();
        bsy   = 0;
        drq   = 0;
        type1 = 1;
        stat  = 8'h00;
        if (trk == 0)
            stat |= fdc_pkg::ST_TRACK0;
        if (active_sides() == 0)
            stat |= fdc_pkg::ST_NOT_READY;
        irq = 1;
    endfunction

    function automatic void open_xfer(int unsigned len, logic is_wr);
        xfer_pos = 0;
        xfer_len = len;
        wr_xfer  = is_wr;
        bsy      = 1;
        drq      = 1;
        stat     = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
        irq      = 1;
    endfunction

    function automatic void close_xfer();
        drq   = 0;
        bsy   = 0;
        type1 = 0;
        stat  = (active_sides() == 0) ? fdc_pkg::ST_NOT_READY : 8'h00;
        irq   = 1;
    endfunction

    function automatic void exec_command(logic [7:0] v);
        int unsigned off;
        logic [7:0]  id;
        cmd  = v;
        drq  = 0;
        bsy  = 1;
        stat = fdc_pkg::ST_BUSY;
        case (v[7:4])
            fdc_pkg::OP_RESTORE:
            begin
                trk = 0;
                finish_seek();
            end
            fdc_pkg::OP_STEP_A, fdc_pkg::OP_STEP_B:
            begin
                if (v[2])
                begin
                    if (trk > 0)
                        trk--;
                end
                else if (trk < fdc_pkg::TRACK_LAST)
                    trk++;
                finish_seek();
            end
            fdc_pkg::OP_IN_A, fdc_pkg::OP_IN_B:
            begin
                if (trk < fdc_pkg::TRACK_LAST)
                    trk++;
                finish_seek();
            end
            fdc_pkg::OP_OUT_A, fdc_pkg::OP_OUT_B:
            begin
                if (trk > 0)
                    trk--;
                finish_seek();
            end
            fdc_pkg::OP_READ_A, fdc_pkg::OP_READ_B:
            begin
                type1 = 0;
                if (!locate_sector(off))
                begin
                    bsy  = 0;
                    drq  = 0;
                    stat = fdc_pkg::ST_NOT_READY;
                    irq  = 1;
                end
                else
                begin
                    for (int i = 0; i < SECT_BYTES; i++)
                        sbuf[i] = disk[off + i];
                    open_xfer(SECT_BYTES, 0);
                end
            end
            fdc_pkg::OP_WRITE_A, fdc_pkg::OP_WRITE_B:
            begin
                type1 = 0;
                if (!locate_sector(off))
                begin
                    bsy  = 0;
                    drq  = 0;
                    stat = fdc_pkg::ST_NOT_READY;
                    irq  = 1;
                end
                else
                    open_xfer(SECT_BYTES, 1);
            end
            fdc_pkg::OP_READ_ID:
            begin
                id = sec;
                if (active_sides() > 1 && side && id < SECT_COUNT)
                    id = id + SECT_COUNT;
                sbuf[0] = trk;
                sbuf[1] = {7'd0, side};
                sbuf[2] = id;
                sbuf[3] = 8'd2;
                sbuf[4] = 8'd0;
                sbuf[5] = 8'd0;
                type1   = 0;
                open_xfer(6, 0);
            end
            default:
                finish_seek();
        endcase
    endfunction

    function automatic logic [7:0] status_byte();
        logic [7:0] st;
        st = stat;
        if (bsy)
            st |= fdc_pkg::ST_BUSY;
        if (drq)
            st |= fdc_pkg::ST_DRQ;
        if (!bsy)
        begin
            if (active_sides() == 0)
                st |= fdc_pkg::ST_NOT_READY;
            if (type1)
            begin
                phase = phase + 1;
                if (phase[5])
                    st |= fdc_pkg::ST_INDEX;
                if (trk == 0)
                    st |= fdc_pkg::ST_TRACK0;
            end
        end
        return st;
    endfunction

    function automatic logic [7:0] data_read();
        logic [7:0] v;
        if (!drq || wr_xfer || xfer_pos >= xfer_len || xfer_pos >= SECT_BYTES)
            return 8'h00;
        v = sbuf[xfer_pos];
        xfer_pos++;
        if (xfer_pos >= xfer_len)
        begin
            close_xfer();
            if (cmd[7:4] == fdc_pkg::OP_READ_ID)
                sec = sbuf[0];
        end
        else
        begin
            irq  = 1;
            stat = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
        end
        return v;
    endfunction

    function automatic void data_write(logic [7:0] v);
        int unsigned off;
        if (!wr_xfer || !drq || xfer_pos >= xfer_len || xfer_pos >= SECT_BYTES)
            return;
        sbuf[xfer_pos] = v;
        xfer_pos++;
        if (xfer_pos >= xfer_len)
        begin
            if (locate_sector(off))
                for (int i = 0; i < SECT_BYTES; i++)
                    disk[off + i] = sbuf[i];
            close_xfer();
        end
        else
        begin
            irq  = 1;
            stat = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
        end
    endfunction

    // Expected result of one item; updates the shadow state
    function automatic fdc_pkg::out_item_t predict_result(fdc_pkg::in_item_t it);
        fdc_pkg::out_item_t r;
        r.read_data = 8'h00;
        case (it.mode)
            fdc_pkg::MODE_BUS_RD:
                case (it.reg_sel)
                    fdc_pkg::REG_STATUS: r.read_data = status_byte();
                    fdc_pkg::REG_TRACK:  r.read_data = trk;
                    fdc_pkg::REG_SECTOR: r.read_data = sec;
                    default:             r.read_data = data_read();
                endcase
            fdc_pkg::MODE_BUS_WR:
                case (it.reg_sel)
                    fdc_pkg::REG_STATUS: exec_command(it.wdata);
                    fdc_pkg::REG_TRACK:  trk = it.wdata;
                    fdc_pkg::REG_SECTOR: sec = it.wdata;
                    default:             data_write(it.wdata);
                endcase
            fdc_pkg::MODE_PORT:
            begin
                if (it.wdata[1:0] == 2'b10)
                    drv = 0;
                else if (it.wdata[1:0] == 2'b01)
                    drv = 1;
                side = ~it.wdata[2];
            end
            fdc_pkg::MODE_TICK:
                phase = phase + 1;
            fdc_pkg::MODE_LOAD:
                disk[it.load_drive * IMG_BYTES + it.load_addr] = it.wdata;
            fdc_pkg::MODE_CLR:
                irq = 0;
            default:
                ;
        endcase
        r.interrupt_request = irq;
        return r;
    endfunction

    // Queue one item; a read of a sector never fully written becomes a write
    task automatic push_item(logic [2:0] m, logic [1:0] r, logic [7:0] wd,
                             logic ld = 0, logic [18:0] la = 0);
        fdc_pkg::in_item_t it;
        int unsigned       off;
        it = '{mode: m, reg_sel: r, wdata: wd, load_drive: ld, load_addr: la};
        if (m == fdc_pkg::MODE_BUS_WR && r == fdc_pkg::REG_STATUS &&
            (wd[7:4] == fdc_pkg::OP_READ_A || wd[7:4] == fdc_pkg::OP_READ_B) &&
            locate_sector(off) && !sector_loaded(off))
            it.wdata = {fdc_pkg::OP_WRITE_A, wd[3:0]};
        expected_results.push_back(predict_result(it));
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        @(posedge clk);
        while (busy || start)
            @(posedge clk);
    endtask

    task automatic write_sides(logic [1:0] a, logic [1:0] b);
        cfg_valid <= 1'b1;
        cfg_index <= fdc_pkg::CFG_FIRST_SIDES;
        cfg_data  <= a;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= fdc_pkg::CFG_SECOND_SIDES;
        cfg_data  <= b;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sides_a = a;
        sides_b = b;
    endtask

    function automatic logic [7:0] pick_pos();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    endfunction

    // Random traffic, mostly command sequences with data bursts
    task automatic random_traffic(int n);
        int          cnt, k, sel;
        logic [7:0]  c;
        cnt = 0;
        while (cnt < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                push_item(fdc_pkg::MODE_PORT, fdc_pkg::REG_STATUS, 8'($urandom));
                cnt++;
            end
            else if (sel < 20)
            begin
                push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_TRACK, pick_pos());
                cnt++;
            end
            else if (sel < 30)
            begin
                push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_SECTOR, pick_pos());
                cnt++;
            end
            else if (sel < 48)
            begin
                c = 8'($urandom);
                if ($urandom_range(0, 2) != 0)
                    c[7] = 1'b1;
                push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, c);
                k = $urandom_range(0, 12);
                for (int i = 0; i < k; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_STATUS, 8'h00);
                    else if (c[7:4] == fdc_pkg::OP_WRITE_A || c[7:4] == fdc_pkg::OP_WRITE_B)
                        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_DATA, 8'($urandom));
                    else
                        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_DATA, 8'h00);
                end
                cnt += 1 + k;
            end
            else if (sel < 62)
            begin
                push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_STATUS, 8'($urandom));
                cnt++;
            end
            else if (sel < 70)
            begin
                push_item($urandom_range(0, 1) ? fdc_pkg::MODE_BUS_RD : fdc_pkg::MODE_BUS_WR,
                          fdc_pkg::REG_DATA, 8'($urandom));
                cnt++;
            end
            else if (sel < 77)
            begin
                push_item(fdc_pkg::MODE_TICK, 2'($urandom), 8'($urandom));
                cnt++;
            end
            else if (sel < 83)
            begin
                push_item(fdc_pkg::MODE_CLR, 2'($urandom), 8'($urandom));
                cnt++;
            end
            else if (sel < 88)
            begin
                push_item(fdc_pkg::MODE_BUS_RD,
                          $urandom_range(0, 1) ? fdc_pkg::REG_TRACK : fdc_pkg::REG_SECTOR,
                          8'h00);
                cnt++;
            end
            else if (sel < 94)
            begin
                push_item(fdc_pkg::MODE_LOAD, 2'($urandom), 8'($urandom), 1'($urandom),
                          19'($urandom));
                cnt++;
            end
            else
            begin
                push_item(3'($urandom), 2'($urandom), 8'($urandom), 1'($urandom), 19'($urandom));
                cnt++;
            end
        end
    endtask

    // Stimulus and configuration phases
    initial
    begin
        logic [1:0] cfg_a [5] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2};
        logic [1:0] cfg_b [5] = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2};
        trk = 0; sec = 0; side = 0; drv = 0; cmd = 0; stat = 0;
        drq = 0; bsy = 0; irq = 0; wr_xfer = 0; type1 = 1;
        xfer_pos = 0; xfer_len = SECT_BYTES; phase = 0;
        sides_a = 0; sides_b = 0;
        errors = 0;
        quiet = 0;
        cfg_valid = 1'b0;
        cfg_index = fdc_pkg::CFG_FIRST_SIDES;
        cfg_data = 2'd0;
        wait (rst_n);
        @(posedge clk);

        // no disk: reads and commands fail as not ready
        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_STATUS, 8'h00);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_READ_A, 4'h0});
        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_DATA, 8'h00);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_DATA, 8'hFF);
        push_item(MODE_SPARE_A, fdc_pkg::REG_DATA, 8'hFF, 1'b1, 19'h7FFFF);
        push_item(MODE_SPARE_B, fdc_pkg::REG_TRACK, 8'h55);
        wait_idle();
        write_sides(2'd2, 2'd1);

        // a few image loads
        for (int a = 0; a < 4; a++)
            push_item(fdc_pkg::MODE_LOAD, fdc_pkg::REG_STATUS, 8'($urandom), 1'b1, 19'(a));
        push_item(fdc_pkg::MODE_LOAD, fdc_pkg::REG_DATA, 8'hA5, 1'b1, 19'h7FFFF);

        // fill track 0 sector 0 of drive 0 through a full sector write
        push_item(fdc_pkg::MODE_PORT, fdc_pkg::REG_STATUS, 8'h06);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_WRITE_A, 4'h0});
        for (int a = 0; a < SECT_BYTES; a++)
            push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_DATA, 8'($urandom));

        // directed corner cases
        push_item(fdc_pkg::MODE_PORT, fdc_pkg::REG_STATUS, 8'h06);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_READ_A, 4'h0});
        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_DATA, 8'h00);
        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_DATA, 8'h00);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_TRACK, 8'd39);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_IN_A, 4'h0});
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_STEP_A, 4'h0});
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_RESTORE, 4'h0});
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_OUT_B, 4'hF});
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_STEP_B, 4'h4});
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_TRACK, 8'hFF);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_SECTOR, 8'hFF);
        push_item(fdc_pkg::MODE_PORT, fdc_pkg::REG_STATUS, 8'h03);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_READ_ID, 4'h0});
        for (int i = 0; i < 6; i++)
            push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_DATA, 8'h00);
        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_SECTOR, 8'h00);
        push_item(fdc_pkg::MODE_PORT, fdc_pkg::REG_STATUS, 8'h01);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, {fdc_pkg::OP_WRITE_B, 4'h0});
        push_item(fdc_pkg::MODE_CLR, fdc_pkg::REG_STATUS, 8'h00);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, CMD_FORCE);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, 8'hE0);
        push_item(fdc_pkg::MODE_BUS_WR, fdc_pkg::REG_STATUS, 8'hFF);
        push_item(fdc_pkg::MODE_TICK, fdc_pkg::REG_STATUS, 8'h00);
        push_item(fdc_pkg::MODE_BUS_RD, fdc_pkg::REG_STATUS, 8'h00);

        // random phases over the sides settings
        for (int p = 0; p < 5; p++)
        begin
            random_traffic(10);
            wait_idle();
            if (p == 4)
                quiet = 1;
            write_sides(cfg_a[p], cfg_b[p]);
        end
        random_traffic(10);
        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Driver: offers queued items, with random gaps
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
            gap   = 0;
        end
        else if (!(start && busy))
        begin
            if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item  <= pending_items.pop_front();
                start <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    gap = $urandom_range(1, 9);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor and watchdog
    int idle_cycles;
    always @(posedge clk)
    begin
        fdc_pkg::out_item_t want;
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, actual %h", $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.read_data !== want.read_data)
                    begin
                        errors++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, result.read_data);
                    end
                    if (result.interrupt_request !== want.interrupt_request)
                    begin
                        errors++;
                        $display("%0t: interrupt_request expected %b actual %b",
                                 $time, want.interrupt_request, result.interrupt_request);
                    end
                end
            end
        end
    end

endmodule
